@@ sv/pwle_pkg.sv @@
// Shared widths, codes and state type for the piecewise-linear envelope.
package pwle_pkg;

  localparam int VAL_W            = 16;
  localparam int DUR_W            = 24;
  localparam int TIME_W           = 32;
  localparam int SLOT_W           = 3;
  localparam int CNT_W            = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int MAX_SEGMENTS_DEF = 8;
  // Interpolation quotient never exceeds the 16-bit value delta.
  localparam int QUO_W            = VAL_W + 1;
  localparam int MAG_W            = VAL_W;
  localparam int TOT_W            = DUR_W + CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 2'd0,
    CFG_MIN   = 2'd1,
    CFG_MAX   = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXAM,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ sv/pwle_cfg_if.sv @@
// Configuration write channel of the envelope.
interface pwle_cfg_if;
  import pwle_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/pwle_req_if.sv @@
// Request channel of the envelope: segment writes and evaluations.
interface pwle_req_if;
  import pwle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [SLOT_W-1:0]        seg_index;
  logic signed [VAL_W-1:0]  seg_target;
  logic [DUR_W-1:0]         seg_duration;
  logic [TIME_W-1:0]        elapsed_time;
  modport source (output valid, req_type, seg_index, seg_target, seg_duration,
                  elapsed_time, input ready);
  modport sink   (input valid, req_type, seg_index, seg_target, seg_duration,
                  elapsed_time, output ready);
endinterface

@@ sv/pwle_rsp_if.sv @@
// Result channel of the envelope.
interface pwle_rsp_if;
  import pwle_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    changed;
  logic                    finished;
  modport source (output valid, value, changed, finished, input ready);
  modport sink   (input valid, value, changed, finished, output ready);
endinterface

@@ sv/piecewise_linear_envelope.sv @@
// Piecewise-linear envelope evaluator: segment table, walk sequencer and shared divider.
//
// A write request stores one segment (target, duration) into a table of MAX_SEGMENTS
// entries. An evaluate request walks the first segment_count segments one at a time
// through the table's single registered read port, a READ and an EXAM state per
// segment, accumulating the total duration on the way. The segment that is reached
// with time left inside it is interpolated with one 16x24 multiply and a 17-step
// restoring division that reuses the walk's subtractor. The request side is not ready
// while an evaluation runs; a finished result waits in the output register and the
// next request is taken while it waits. Configuration writes are always taken and
// must only be issued while the block is idle.
module piecewise_linear_envelope #(
  parameter int MAX_SEGMENTS = pwle_pkg::MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pwle_cfg_if.sink          cfg,
  pwle_req_if.sink          req,
  pwle_rsp_if.source        rsp
);
  import pwle_pkg::*;

  localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CTR_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int ENT_W  = VAL_W + DUR_W;
  localparam int STEP_W = $clog2(QUO_W);
  localparam int REM_W  = DUR_W;
  localparam int PROD_W = MAG_W + DUR_W;
  localparam int SUB_W  = TIME_W + 1;

  state_t state, state_next;

  // Configuration and stored value
  logic signed [VAL_W-1:0] start_value, min_value, max_value, cur_value;
  logic [CNT_W-1:0]        seg_count;

  // Segment table
  logic [ENT_W-1:0]        seg_mem [MAX_SEGMENTS];
  logic [ENT_W-1:0]        rd_data;
  logic signed [VAL_W-1:0] rd_target;
  logic [DUR_W-1:0]        rd_dur;

  // Walk state
  logic [CTR_W-1:0]        ctr, n_lim;
  logic [CTR_W:0]          count_wide;
  logic [TIME_W-1:0]       elapsed, time_left;
  logic [TOT_W-1:0]        total;
  logic signed [VAL_W-1:0] walk_value;
  logic                    hit, div_pend, dv_neg;
  logic [MAG_W-1:0]        dv_mag;
  logic [DUR_W-1:0]        mul_time, div_dur;

  // Divider state
  logic [REM_W-1:0]        rem, rem_next;
  logic [QUO_W-1:0]        quo;
  logic [STEP_W-1:0]       step;

  // Output register
  logic                    out_valid, out_changed, out_finished;
  logic signed [VAL_W-1:0] out_value;

  // Control
  logic                    req_acc, eval_acc, wr_acc, exam_en, mul_en, div_en, done_fire;
  logic                    walk_end, div_last, busy;

  // Shared subtractor
  logic [SUB_W-1:0]        sub_a, sub_b, sub_diff;
  logic                    sub_borrow, seg_passes;

  // Datapath helpers
  logic signed [VAL_W:0]   dv, dv_abs;
  logic [PROD_W-1:0]       prod;
  logic signed [VAL_W+1:0] q_ext, q_add, v_sum;
  logic signed [VAL_W-1:0] v_final, v_hi, v_clamped;
  logic                    val_changed, env_finished;

  assign rd_target = signed'(rd_data[ENT_W-1:DUR_W]);
  assign rd_dur    = rd_data[DUR_W-1:0];

  // Clip the count to the table depth
  assign count_wide = (CTR_W+1)'(seg_count);
  assign n_lim = (count_wide > (CTR_W+1)'(MAX_SEGMENTS)) ? CTR_W'(MAX_SEGMENTS)
                                                          : CTR_W'(seg_count);

  // Accept conditions
  assign req_acc  = req.valid & req.ready;
  assign eval_acc = req_acc & (req.req_type == REQ_EVAL);
  assign wr_acc   = req_acc & (req.req_type == REQ_WRITE) &
                    (32'(req.seg_index) < MAX_SEGMENTS);

  assign walk_end = (ctr == n_lim);
  assign div_last = (step == STEP_W'(QUO_W - 1));

  // Shared subtract: remaining time minus duration, or partial remainder minus divisor
  always_comb begin
    if (state == ST_DIV) begin
      sub_a = SUB_W'({rem, quo[QUO_W-1]});
      sub_b = SUB_W'(div_dur);
    end else begin
      sub_a = {1'b0, time_left};
      sub_b = SUB_W'(rd_dur);
    end
    sub_diff   = sub_a - sub_b;
    sub_borrow = sub_diff[SUB_W-1];
    seg_passes = !sub_borrow && (sub_diff != '0);
    rem_next   = sub_borrow ? REM_W'({rem, quo[QUO_W-1]}) : sub_diff[REM_W-1:0];
  end

  // Delta toward the reached segment's target
  assign dv     = {rd_target[VAL_W-1], rd_target} - {walk_value[VAL_W-1], walk_value};
  assign dv_abs = dv[VAL_W] ? -dv : dv;

  // Scale the delta magnitude by the time into the segment
  assign prod = PROD_W'(dv_mag) * PROD_W'(mul_time);

  // Final value, clamp and flags
  assign q_ext     = signed'({1'b0, quo});
  assign q_add     = div_pend ? (dv_neg ? -q_ext : q_ext) : '0;
  assign v_sum     = {{2{walk_value[VAL_W-1]}}, walk_value} + q_add;
  assign v_final   = v_sum[VAL_W-1:0];
  assign val_changed  = (v_final != cur_value);
  assign v_hi      = (v_final > max_value) ? max_value : v_final;
  assign v_clamped = (v_hi < min_value) ? min_value : v_hi;
  assign env_finished = (TIME_W'(total) <= elapsed);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (eval_acc) state_next = ST_READ;
      ST_READ: begin
        if (walk_end) state_next = div_pend ? ST_MUL : ST_DONE;
        else          state_next = ST_EXAM;
      end
      ST_EXAM: state_next = ST_READ;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_DONE;
      ST_DONE: if (!out_valid || rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = 1'b1;
    exam_en   = 1'b0;
    mul_en    = 1'b0;
    div_en    = 1'b0;
    done_fire = 1'b0;
    case (state)
      ST_IDLE: busy      = 1'b0;
      ST_EXAM: exam_en   = 1'b1;
      ST_MUL:  mul_en    = 1'b1;
      ST_DIV:  div_en    = 1'b1;
      ST_DONE: done_fire = !out_valid || rsp.ready;
      default: busy      = 1'b1;
    endcase
  end

  assign req.ready    = !busy;
  assign cfg.ready    = 1'b1;
  assign rsp.valid    = out_valid;
  assign rsp.value    = out_value;
  assign rsp.changed  = out_changed;
  assign rsp.finished = out_finished;

  // Control registers, configuration and stored value
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      start_value <= '0;
      min_value   <= {1'b1, {(VAL_W-1){1'b0}}};
      max_value   <= {1'b0, {(VAL_W-1){1'b1}}};
      seg_count   <= '0;
      cur_value   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_START: start_value <= signed'(cfg.data[VAL_W-1:0]);
          CFG_MIN:   min_value   <= signed'(cfg.data[VAL_W-1:0]);
          CFG_MAX:   max_value   <= signed'(cfg.data[VAL_W-1:0]);
          CFG_COUNT: seg_count   <= cfg.data[CNT_W-1:0];
          default:   seg_count   <= seg_count;
        endcase
      end
      if (done_fire) begin
        out_valid <= 1'b1;
        if (val_changed) cur_value <= v_clamped;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Segment table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_acc) seg_mem[IDX_W'(req.seg_index)] <= {req.seg_target, req.seg_duration};
    rd_data <= seg_mem[ctr[IDX_W-1:0]];
  end

  // Walk, multiply and divide datapath
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      ctr        <= '0;
      elapsed    <= req.elapsed_time;
      time_left  <= req.elapsed_time;
      total      <= '0;
      walk_value <= start_value;
      hit        <= 1'b0;
      div_pend   <= 1'b0;
    end
    if (exam_en) begin
      ctr   <= ctr + 1'b1;
      total <= total + TOT_W'(rd_dur);
      if (!hit) begin
        if (seg_passes) begin
          // pass the whole segment
          walk_value <= rd_target;
          time_left  <= sub_diff[TIME_W-1:0];
        end else begin
          hit <= 1'b1;
          if (rd_dur == '0) begin
            walk_value <= rd_target;
          end else begin
            div_pend <= 1'b1;
            dv_neg   <= dv[VAL_W];
            dv_mag   <= dv_abs[MAG_W-1:0];
            mul_time <= time_left[DUR_W-1:0];
            div_dur  <= rd_dur;
          end
        end
      end
    end
    if (mul_en) begin
      // upper product bits are already below the divisor
      rem  <= REM_W'(prod[PROD_W-1:QUO_W]);
      quo  <= prod[QUO_W-1:0];
      step <= '0;
    end
    if (div_en) begin
      rem  <= rem_next;
      quo  <= {quo[QUO_W-2:0], !sub_borrow};
      step <= step + 1'b1;
    end
    if (done_fire) begin
      out_value    <= val_changed ? v_clamped : cur_value;
      out_changed  <= val_changed;
      out_finished <= env_finished;
    end
  end

`ifndef ASSERT_OFF
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXAM) |-> (ctr < n_lim))
    else $error("segment walk ran past the segments in use");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < div_dur))
    else $error("partial remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (div_pend && (state == ST_MUL || state == ST_DIV)) |-> (div_dur != '0))
    else $error("interpolation started with zero duration");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done step");

  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    (eval_acc) |=> (!req.ready))
    else $error("request taken while an evaluation runs");
`endif

endmodule
